FILE: design/kls_pkg.sv
// Package for the k-th largest stream selector.
// Holds the item types, the cell control struct and fixed widths; no dependencies.
`default_nettype none

package kls_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int RANK_WIDTH  = 7;

	localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] sample_value;
		logic                          set_end;
	} sample_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] rank_value;
		logic                          short_set;
	} result_t;

	// Broadcast control from the top level to every cell of the chain
	typedef struct packed {
		logic load;    // an item is accepted this cycle
		logic append;  // fewer than k values kept: insert without dropping
		logic clear;   // last item of the set: empty the chain after the update
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/kls_cell.sv
// One cell of the sorted chain: holds one kept value and its valid bit.
// Depends on kls_pkg; neighbours are the next smaller (lo) and next larger (hi) cell.
`default_nettype none

module kls_cell import kls_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cell_ctl_t                     ctl,
	input  wire logic signed [VALUE_WIDTH-1:0] sample_value,
	input  wire logic signed [VALUE_WIDTH-1:0] lo_value,
	input  wire logic                          lo_valid,
	input  wire logic signed [VALUE_WIDTH-1:0] hi_value,
	input  wire logic                          hi_valid,
	output logic signed [VALUE_WIDTH-1:0]      value,
	output logic                               valid,
	output logic signed [VALUE_WIDTH-1:0]      value_nxt
);

	logic signed [VALUE_WIDTH-1:0] value_q;
	logic                          valid_q;
	logic                          valid_nxt;

	always_comb begin
		value_nxt = value_q;
		valid_nxt = valid_q;
		if (ctl.append) begin
			// insert: keep if not above the sample, else take the sample or shift up
			if (valid_q && (value_q <= sample_value)) begin
				value_nxt = value_q;
				valid_nxt = 1'b1;
			end else if (lo_valid && (lo_value <= sample_value)) begin
				value_nxt = sample_value;
				valid_nxt = 1'b1;
			end else begin
				value_nxt = lo_value;
				valid_nxt = lo_valid;
			end
		end else if (valid_q) begin
			// replace: drop the smallest, shift down below the insertion point
			if (hi_valid && (sample_value > hi_value)) begin
				value_nxt = hi_value;
			end else if (sample_value > value_q) begin
				value_nxt = sample_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= value_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= ctl.clear ? 1'b0 : valid_nxt;
		end
	end

	assign value = value_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

FILE: design/kth_largest_stream_select_unit.sv
// Top level of the k-th largest stream selector: rank register, fill count,
// the sorted cell chain and the result register. Depends on kls_pkg and kls_cell.
// Throughput: one item per cycle unless a finished result waits and is not taken.
// Result: valid in the cycle after the item marked set_end is accepted. Both
// follow from the compare-and-shift that every cell of the chain performs on each item.
// Reset: fill count and cell valid bits clear, rank reads 1, no result pending;
// kept values are undefined until written and never read while invalid.
`default_nettype none

module kth_largest_stream_select_unit import kls_pkg::*; #(
	parameter int RANK_MAX = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration: select_rank
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [RANK_WIDTH-1:0] cfg_data,
	// item stream
	input  wire logic                  sample_valid,
	output logic                       sample_ready,
	input  wire sample_t               sample,
	// result stream
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output result_t                    result
);

	localparam int CNT_W = $clog2(RANK_MAX + 1);
	localparam int KW    = (CNT_W > RANK_WIDTH) ? CNT_W : RANK_WIDTH;

	logic [RANK_WIDTH-1:0] select_rank_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic                  result_valid_q;
	result_t               result_q;

	logic [KW-1:0]         sel_ext;
	logic [KW-1:0]         rank_eff;
	logic                  append;
	logic                  sample_fire;
	cell_ctl_t             ctl;

	logic signed [VALUE_WIDTH-1:0] cell_value [RANK_MAX];
	logic signed [VALUE_WIDTH-1:0] cell_nxt   [RANK_MAX];
	logic [RANK_MAX-1:0]           cell_valid;

	// Configuration: always ready; the user must write it only while the block is idle (not enforced here)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_rank_q <= RANK_WIDTH'(1);
		end else if (cfg_valid) begin
			select_rank_q <= cfg_data;
		end
	end

	// Clamp the rank: zero acts as one, anything above the chain length as the length
	always_comb begin
		sel_ext = KW'(select_rank_q);
		if (sel_ext == '0) begin
			rank_eff = KW'(1);
		end else if (sel_ext > KW'(RANK_MAX)) begin
			rank_eff = KW'(RANK_MAX);
		end else begin
			rank_eff = sel_ext;
		end
	end

	// Append while fewer than k values are kept; otherwise compete with the smallest
	assign append    = KW'(count_q) < rank_eff;
	assign count_nxt = count_q + CNT_W'(append);

	// Accept an item unless a result still waits and cannot leave this cycle
	assign sample_ready = !result_valid_q || result_ready;
	assign sample_fire  = sample_valid && sample_ready;

	assign ctl.load   = sample_fire;
	assign ctl.append = append;
	assign ctl.clear  = sample.set_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (sample_fire) begin
			count_q <= sample.set_end ? '0 : count_nxt;
		end
	end

	// Chain kept in ascending order: cell 0 holds the smallest kept value.
	// Cell 0 sees a valid lower neighbour at the most negative value so it always
	// takes the sample when it is the insertion point; the top cell has no upper one.
	for (genvar i = 0; i < RANK_MAX; i++) begin : g_cell
		logic signed [VALUE_WIDTH-1:0] lo_value;
		logic                          lo_valid;
		logic signed [VALUE_WIDTH-1:0] hi_value;
		logic                          hi_valid;

		if (i == 0) begin : g_lo_edge
			assign lo_value = VALUE_MIN;
			assign lo_valid = 1'b1;
		end else begin : g_lo
			assign lo_value = cell_value[i-1];
			assign lo_valid = cell_valid[i-1];
		end

		if (i == RANK_MAX - 1) begin : g_hi_edge
			assign hi_value = VALUE_MIN;
			assign hi_valid = 1'b0;
		end else begin : g_hi
			assign hi_value = cell_value[i+1];
			assign hi_valid = cell_valid[i+1];
		end

		kls_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.sample_value (sample.sample_value),
			.lo_value     (lo_value),
			.lo_valid     (lo_valid),
			.hi_value     (hi_value),
			.hi_valid     (hi_valid),
			.value        (cell_value[i]),
			.valid        (cell_valid[i]),
			.value_nxt    (cell_nxt[i])
		);
	end

	// Result register: capture the updated smallest value on the last item,
	// hold it until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (sample_fire && sample.set_end) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_fire && sample.set_end) begin
			result_q.rank_value <= cell_nxt[0];
			result_q.short_set  <= KW'(count_nxt) < rank_eff;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// Valid bits form the thermometer of the fill count
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("cell valid bits disagree with fill count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= RANK_MAX)
		else $error("fill count beyond chain length");

	a_clear_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_fire && sample.set_end) |=> (count_q == '0) && (cell_valid == '0))
		else $error("chain not cleared after last item");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(sample_fire && sample.set_end))
		else $error("result raised without a last item");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_fire && !sample.set_end && append) |=> count_q == $past(count_q) + 1'b1)
		else $error("append did not grow the fill count");
`endif

endmodule

`default_nettype wire
